@@ rtl/rsmp_pkg.sv @@
`default_nettype none

package rsmp_pkg;

  // Fixed widths of the sample path, the configuration registers and the phase.
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned RATE_W   = 18;
  localparam int unsigned ACC_W    = 36;

  // Defaults for the top-level parameters.
  localparam int unsigned PHASE_FRAC_BITS_DEF = 32;
  localparam int unsigned MAX_OUT_PER_IN_DEF  = 8;

  // Rates after reset.
  localparam logic [RATE_W-1:0] SOURCE_RATE_RST = RATE_W'(24000);
  localparam logic [RATE_W-1:0] TARGET_RATE_RST = RATE_W'(48000);

  // Clamp limits of an interpolated sample.
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = -16'sh8000;

  // Saturated phase value.
  localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};

  // Configuration register indexes.
  typedef enum logic [0:0] {
    CFG_SOURCE_RATE = 1'b0,
    CFG_TARGET_RATE = 1'b1
  } cfg_idx_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_LOAD,
    ST_DIV,
    ST_IDLE,
    ST_MUL,
    ST_ADD,
    ST_HOLD,
    ST_FIN
  } rsmp_state_e;

endpackage

`default_nettype wire

@@ rtl/rsmp_in_if.sv @@
`default_nettype none

interface rsmp_in_if
  import rsmp_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] in_sample;

  modport source (output valid, output in_sample, input ready);
  modport sink   (input valid, input in_sample, output ready);
endinterface

`default_nettype wire

@@ rtl/rsmp_out_if.sv @@
`default_nettype none

interface rsmp_out_if
  import rsmp_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] out_sample;
  logic                       last;

  modport source (output valid, output out_sample, output last, input ready);
  modport sink   (input valid, input out_sample, input last, output ready);
endinterface

`default_nettype wire

@@ rtl/linear_interp_resampler_core.sv @@
// Linear-interpolation sample-rate converter for signed 16-bit mono audio.
// Input channel in_if: one sample per beat. Output channel out_if: one
// interpolated sample per beat, with last set on the final beat caused by
// an input sample. Rates are written through cfg_we_i / cfg_idx_i /
// cfg_wdata_i; every write clears the stream state and restarts the step
// derivation.
// The phase step (source over target rate) comes from a bit-serial restoring
// divider: a load state, then one quotient bit per cycle, run after reset or
// after a rate write. No sample is taken meanwhile.
// One sample is processed at a time. After a sample is accepted, each output
// goes through multiply, add and clamp, and hand over, using the single shared
// multiplier, and a closing step then updates the phase. Unless the rates are
// equal, the first sample after reset or a write gives no output. Equal rates
// pass a sample straight through.
// A stalled receiver holds the output register and the sequencer waits;
// in_if.ready stays low until all outputs of the current sample are taken.
// After reset both rates hold their defaults and the phase, held sample and
// first-sample flag are cleared.
`default_nettype none

module linear_interp_resampler_core
  import rsmp_pkg::*;
#(
  parameter int unsigned PhaseFracBits = PHASE_FRAC_BITS_DEF,
  parameter int unsigned MaxOutPerIn   = MAX_OUT_PER_IN_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire cfg_idx_e            cfg_idx_i,
  input  wire logic [RATE_W-1:0]   cfg_wdata_i,
  rsmp_in_if.sink                  in_if,
  rsmp_out_if.source               out_if
);

  localparam int unsigned NUM_W = RATE_W + PhaseFracBits;
  localparam int unsigned EXT_W = (NUM_W > ACC_W) ? NUM_W : ACC_W + 1;
  localparam int unsigned DCNT_W = $clog2(NUM_W);
  localparam int unsigned CNT_W = $clog2(MaxOutPerIn + 1);
  localparam int unsigned PROD_W = 2 * SAMPLE_W;

  rsmp_state_e state_q, state_d;

  logic [RATE_W-1:0]          src_q, src_d, tgt_q, tgt_d;
  logic [ACC_W-1:0]           acc_q, acc_d, step_q, step_d;
  logic signed [SAMPLE_W-1:0] held_q, held_d, cur_q, cur_d, out_q, out_d;
  logic                       seen_q, seen_d;
  logic [CNT_W-1:0]           cnt_q, cnt_d;
  logic                       pass_q, pass_d, last_q, last_d;
  logic                       out_valid_q, out_valid_d;
  logic signed [PROD_W-1:0]   prod_q, prod_d;
  logic [NUM_W-1:0]           num_q, num_d;
  logic [RATE_W-1:0]          rem_q, rem_d;
  logic [DCNT_W-1:0]          dcnt_q, dcnt_d;

  // Divider datapath.
  logic [RATE_W:0]  trial;
  logic             trial_ge;
  logic [NUM_W-1:0] quot;
  logic [EXT_W-1:0] quot_ext;

  // Phase and interpolation datapath.
  logic                       acc_lt_unit;
  logic [ACC_W:0]             acc_sum;
  logic [ACC_W-1:0]           acc_next;
  logic                       next_lt_unit;
  logic [CNT_W:0]             cnt_inc;
  logic signed [SAMPLE_W:0]   diff;
  logic signed [SAMPLE_W:0]   frac15;
  logic signed [SAMPLE_W+1:0] interp;

  always_comb begin
    trial    = {rem_q, num_q[NUM_W-1]};
    trial_ge = trial >= {1'b0, tgt_q};
    quot     = {num_q[NUM_W-2:0], trial_ge};
    quot_ext = EXT_W'(quot);

    acc_lt_unit  = ~|acc_q[ACC_W-1:PhaseFracBits];
    acc_sum      = {1'b0, acc_q} + {1'b0, step_q};
    acc_next     = acc_sum[ACC_W] ? ACC_MAX : acc_sum[ACC_W-1:0];
    next_lt_unit = ~|acc_next[ACC_W-1:PhaseFracBits];
    cnt_inc      = {1'b0, cnt_q} + (CNT_W + 1)'(1);

    diff   = {cur_q[SAMPLE_W-1], cur_q} - {held_q[SAMPLE_W-1], held_q};
    frac15 = {2'b00, acc_q[PhaseFracBits-1 -: 15]};
    // Floor division by 2^15 is an arithmetic shift of the product.
    interp = {{2{held_q[SAMPLE_W-1]}}, held_q}
           + (SAMPLE_W + 2)'(prod_q >>> 15);
  end

  // Sequencer: next state and register updates.
  always_comb begin
    state_d     = state_q;
    src_d       = src_q;
    tgt_d       = tgt_q;
    acc_d       = acc_q;
    step_d      = step_q;
    held_d      = held_q;
    cur_d       = cur_q;
    out_d       = out_q;
    seen_d      = seen_q;
    cnt_d       = cnt_q;
    pass_d      = pass_q;
    last_d      = last_q;
    out_valid_d = out_valid_q;
    prod_d      = prod_q;
    num_d       = num_q;
    rem_d       = rem_q;
    dcnt_d      = dcnt_q;

    case (state_q)
      ST_LOAD: begin
        num_d   = NUM_W'(src_q) << PhaseFracBits;
        rem_d   = '0;
        dcnt_d  = '0;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        // One quotient bit per cycle.
        rem_d  = trial_ge ? RATE_W'(trial - {1'b0, tgt_q}) : trial[RATE_W-1:0];
        num_d  = quot;
        dcnt_d = dcnt_q + DCNT_W'(1);
        if (dcnt_q == DCNT_W'(NUM_W - 1)) begin
          if (tgt_q == '0 || (|quot_ext[EXT_W-1:ACC_W])) begin
            step_d = ACC_MAX;
          end else begin
            step_d = quot_ext[ACC_W-1:0];
          end
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_if.valid) begin
          if (src_q == tgt_q) begin
            // Equal rates: the sample goes straight out.
            out_d       = in_if.in_sample;
            last_d      = 1'b1;
            pass_d      = 1'b1;
            out_valid_d = 1'b1;
            held_d      = in_if.in_sample;
            seen_d      = 1'b1;
            state_d     = ST_HOLD;
          end else if (!seen_q) begin
            held_d = in_if.in_sample;
            seen_d = 1'b1;
          end else begin
            cur_d   = in_if.in_sample;
            cnt_d   = '0;
            pass_d  = 1'b0;
            state_d = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        if (acc_lt_unit && cnt_q < CNT_W'(MaxOutPerIn)) begin
          prod_d  = PROD_W'(diff) * PROD_W'(frac15);
          acc_d   = acc_next;
          cnt_d   = cnt_inc[CNT_W-1:0];
          last_d  = !(next_lt_unit && cnt_inc < (CNT_W + 1)'(MaxOutPerIn));
          state_d = ST_ADD;
        end else begin
          state_d = ST_FIN;
        end
      end
      ST_ADD: begin
        if (interp > (SAMPLE_W + 2)'(SAMPLE_MAX)) begin
          out_d = SAMPLE_MAX;
        end else if (interp < (SAMPLE_W + 2)'(SAMPLE_MIN)) begin
          out_d = SAMPLE_MIN;
        end else begin
          out_d = interp[SAMPLE_W-1:0];
        end
        out_valid_d = 1'b1;
        state_d     = ST_HOLD;
      end
      ST_HOLD: begin
        if (out_if.ready) begin
          out_valid_d = 1'b0;
          if (!last_q) begin
            state_d = ST_MUL;
          end else if (pass_q) begin
            state_d = ST_IDLE;
          end else begin
            state_d = ST_FIN;
          end
        end
      end
      ST_FIN: begin
        // Move the phase into the next interval.
        acc_d   = acc_lt_unit ? '0 : acc_q - (ACC_W'(1) << PhaseFracBits);
        held_d  = cur_q;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase

    // A rate write clears the stream and derives the step again.
    if (cfg_we_i) begin
      if (cfg_idx_i == CFG_SOURCE_RATE) begin
        src_d = cfg_wdata_i;
      end else begin
        tgt_d = cfg_wdata_i;
      end
      acc_d       = '0;
      held_d      = '0;
      seen_d      = 1'b0;
      out_valid_d = 1'b0;
      state_d     = ST_LOAD;
    end
  end

  // Control and stream state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      src_q       <= SOURCE_RATE_RST;
      tgt_q       <= TARGET_RATE_RST;
      acc_q       <= '0;
      held_q      <= '0;
      seen_q      <= 1'b0;
      cnt_q       <= '0;
      pass_q      <= 1'b0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
      dcnt_q      <= '0;
    end else begin
      state_q     <= state_d;
      src_q       <= src_d;
      tgt_q       <= tgt_d;
      acc_q       <= acc_d;
      held_q      <= held_d;
      seen_q      <= seen_d;
      cnt_q       <= cnt_d;
      pass_q      <= pass_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
      dcnt_q      <= dcnt_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    step_q <= step_d;
    cur_q  <= cur_d;
    out_q  <= out_d;
    prod_q <= prod_d;
    num_q  <= num_d;
    rem_q  <= rem_d;
  end

  assign in_if.ready       = (state_q == ST_IDLE);
  assign out_if.valid      = out_valid_q;
  assign out_if.out_sample = out_q;
  assign out_if.last       = last_q;

endmodule

`default_nettype wire
